// ===== hw/rtl/range_encoder_carry_cache_unit_macros.svh =====
// assertion helpers
`ifndef RANGE_ENCODER_CARRY_CACHE_UNIT_MACROS_SVH
`define RANGE_ENCODER_CARRY_CACHE_UNIT_MACROS_SVH

`define RECC_ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

`define RECC_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/recc_pkg.sv =====
`default_nettype none
package recc_pkg;
   localparam int PendingMax = 16;
   localparam int TailBytes  = 4;
   localparam int MaxResults = 24;
   localparam logic [0:0] ActEncode = 1'b0;
   localparam logic [0:0] ActFlush  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIV_LO, ST_DIV_HI, ST_UPDATE, ST_NORM, ST_EMIT,
      ST_FL_TAIL, ST_FL_EMIT, ST_FL_DONE
   } state_type;

   typedef struct packed {
      logic        start;
      logic [48:0] dividend;
      logic [15:0] divisor;
   } div_req_type;
endpackage
`default_nettype wire

// ===== hw/rtl/recc_divider.sv =====
`default_nettype none
module recc_divider (
   input  wire  logic                     clock,
   input  wire  logic                     reset,
   input  wire  recc_pkg::div_req_type    req,
   output logic                           busy,
   output logic [32:0]                    quotient
);
   logic [48:0] quo_ff, quo_in;
   logic [15:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [15:0] den_ff, den_in;
   logic [16:0] trial;
   logic [16:0] diff;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      den_in = den_ff;
      trial  = {rem_ff, quo_ff[48]};
      diff   = trial - {1'b0, den_ff};
      if (req.start) begin
         quo_in = req.dividend;
         rem_in = '0;
         cnt_in = 6'd49;
         den_in = req.divisor;
      end else if (cnt_ff != 6'd0) begin
         cnt_in = cnt_ff - 6'd1;
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[15:0];
            quo_in = {quo_ff[47:0], 1'b1};
         end else begin
            rem_in = trial[15:0];
            quo_in = {quo_ff[47:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy     = (cnt_ff != 6'd0) || req.start;
   assign quotient = quo_ff[32:0];
endmodule
`default_nettype wire

// ===== hw/rtl/range_encoder_carry_cache_unit.sv =====
// Encode word: accept, then two divisions on the shared bit-serial divider (one quotient
// bit per cycle), an update step and an exit check. A renormalization shift that writes
// bytes is followed by an emit phase that sends them one at a time and waits while the
// output stalls. Bad symbol: accepted and dropped. Flush word: a tail step, an emit phase
// for the remaining bytes (none when empty) and a final clear of the coder state.
// Synchronous reset clears the coder state: low 0, range 2^32, no cache.
`default_nettype none
`include "range_encoder_carry_cache_unit_macros.svh"
module range_encoder_carry_cache_unit (
   input  wire  logic        clock,
   input  wire  logic        reset,
   input  wire  logic        req_tvalid,
   output logic              req_tready,
   input  wire  logic [47:0] req_tdata,  // cum_freq, sym_freq, total_freq
   input  wire  logic        req_tuser,  // action
   output logic              rsp_tvalid,
   input  wire  logic        rsp_tready,
   output logic [7:0]        rsp_tdata,  // out_byte
   output logic              rsp_tlast,  // last_byte
   output logic              rsp_tuser   // overflow
);
   recc_pkg::state_type state_ff, state_in;
   logic [31:0] low_ff, low_in;
   logic        carry_ff, carry_in;
   logic [32:0] range_ff, range_in;
   logic [7:0]  cache_ff, cache_in;
   logic        cvalid_ff, cvalid_in;
   logic [4:0]  pend_ff, pend_in;
   logic        err_ff, err_in;
   logic [15:0] cum_ff, frq_ff, tot_ff;
   logic [32:0] lo_ff, lo_in;
   logic [32:0] q_lo_ff, q_lo_in;
   // emission queue: cached byte, then pendings, then tail
   logic        eq_cache_ff, eq_cache_in;
   logic [7:0]  eq_cbyte_ff, eq_cbyte_in;
   logic [4:0]  eq_pend_ff, eq_pend_in;
   logic [7:0]  eq_pbyte_ff, eq_pbyte_in;
   logic [2:0]  eq_tail_ff, eq_tail_in;
   logic [31:0] eq_tword_ff, eq_tword_in;
   logic [4:0]  nout_ff, nout_in;
   logic        div_phase_ff, div_phase_in;
   recc_pkg::div_req_type dreq;
   logic        dbusy;
   logic [32:0] dq;
   logic        accept, fire, more;
   logic [16:0] cf_sum;
   logic [32:0] hi_val, q_sel;
   logic [32:0] sum33;
   logic [32:0] high_fl, basem;
   logic [2:0]  tail;
   logic [31:0] lw;
   logic [8:0]  csum;
   logic [5:0]  room;

   recc_divider u_div (
      .clock(clock), .reset(reset), .req(dreq), .busy(dbusy), .quotient(dq)
   );

   assign accept = req_tvalid && req_tready;
   assign fire   = rsp_tvalid && rsp_tready;
   assign cf_sum = {1'b0, req_tdata[15:0]} + {1'b0, req_tdata[31:16]};
   assign more   = eq_cache_ff || (eq_pend_ff != 5'd0) || (eq_tail_ff != 3'd0);
   assign q_sel  = dq;
   assign room   = 6'(recc_pkg::MaxResults) - {1'b0, nout_ff};

   function automatic logic more_after_fire();
      logic r;
      r = 1'b0;
      if (eq_cache_ff) r = (eq_pend_ff != 5'd0) || (eq_tail_ff != 3'd0);
      else if (eq_pend_ff != 5'd0) r = (eq_pend_ff != 5'd1) || (eq_tail_ff != 3'd0);
      else r = eq_tail_ff > 3'd1;
      return r;
   endfunction

   // true when no later shift of this word writes a byte
   function automatic logic final_norm();
      logic shift_a, shift_b;
      shift_a = (range_ff < 33'h001000000) && (low_ff < 32'hFF000000 || carry_ff) &&
                (cvalid_ff || pend_ff != 5'd0);
      shift_b = (range_ff < 33'h000010000) && (low_ff[23:16] != 8'hFF);
      return !(shift_a || shift_b);
   endfunction

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         recc_pkg::ST_IDLE:
            if (accept) begin
               if (req_tuser == recc_pkg::ActFlush) state_in = recc_pkg::ST_FL_TAIL;
               else if (req_tdata[47:32] != 16'd0 && req_tdata[31:16] != 16'd0 &&
                        cf_sum <= {1'b0, req_tdata[47:32]})
                  state_in = recc_pkg::ST_DIV_LO;
            end
         recc_pkg::ST_DIV_LO:  if (!dbusy && div_phase_ff) state_in = recc_pkg::ST_DIV_HI;
         recc_pkg::ST_DIV_HI:  if (!dbusy && div_phase_ff) state_in = recc_pkg::ST_UPDATE;
         recc_pkg::ST_UPDATE:  state_in = recc_pkg::ST_NORM;
         recc_pkg::ST_NORM:
            if (more) begin
               if (room != 6'd0) state_in = recc_pkg::ST_EMIT;
            end else if (range_ff >= 33'h001000000) state_in = recc_pkg::ST_IDLE;
         recc_pkg::ST_EMIT:
            if (fire && (!more_after_fire() || room == 6'd1)) state_in = recc_pkg::ST_NORM;
         recc_pkg::ST_FL_TAIL: state_in = recc_pkg::ST_FL_EMIT;
         recc_pkg::ST_FL_EMIT:
            if (!more || (fire && !more_after_fire())) state_in = recc_pkg::ST_FL_DONE;
         recc_pkg::ST_FL_DONE: state_in = recc_pkg::ST_IDLE;
         default: state_in = recc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      low_in = low_ff; carry_in = carry_ff; range_in = range_ff;
      cache_in = cache_ff; cvalid_in = cvalid_ff; pend_in = pend_ff; err_in = err_ff;
      lo_in = lo_ff; q_lo_in = q_lo_ff;
      eq_cache_in = eq_cache_ff; eq_cbyte_in = eq_cbyte_ff;
      eq_pend_in = eq_pend_ff; eq_pbyte_in = eq_pbyte_ff;
      eq_tail_in = eq_tail_ff; eq_tword_in = eq_tword_ff;
      nout_in = nout_ff; div_phase_in = div_phase_ff;
      dreq = '0;
      hi_val = '0; sum33 = '0; high_fl = '0; basem = '0;
      tail = 3'(recc_pkg::TailBytes); lw = low_ff; csum = '0;
      case (state_ff)
         recc_pkg::ST_IDLE: begin
            nout_in = '0;
            div_phase_in = 1'b0;
         end
         recc_pkg::ST_DIV_LO, recc_pkg::ST_DIV_HI: begin
            if (!div_phase_ff) begin
               dreq.start = 1'b1;
               dreq.divisor = tot_ff;
               if (state_ff == recc_pkg::ST_DIV_LO)
                  dreq.dividend = {16'd0, range_ff} * {33'd0, tot_ff - cum_ff};
               else
                  dreq.dividend = {16'd0, range_ff} * {33'd0, tot_ff - cum_ff - frq_ff};
               div_phase_in = 1'b1;
            end else if (!dbusy) begin
               div_phase_in = 1'b0;
               if (state_ff == recc_pkg::ST_DIV_LO) q_lo_in = q_sel;
               else begin
                  lo_in = range_ff - q_lo_ff;
                  hi_val = range_ff - q_sel;
                  range_in = hi_val - (range_ff - q_lo_ff);
               end
            end
         end
         recc_pkg::ST_UPDATE: begin
            sum33 = {carry_ff, low_ff} + lo_ff;
            low_in = sum33[31:0];
            carry_in = sum33[32];
         end
         recc_pkg::ST_NORM: begin
            if (!more && range_ff < 33'h001000000) begin
               range_in = {range_ff[24:0], 8'd0};
               if (low_ff < 32'hFF000000 || carry_ff) begin
                  eq_cache_in = cvalid_ff;
                  eq_cbyte_in = cache_ff + {7'd0, carry_ff};
                  eq_pend_in  = pend_ff;
                  eq_pbyte_in = 8'hFF + {7'd0, carry_ff};
                  pend_in = '0;
                  cache_in = low_ff[31:24];
                  cvalid_in = 1'b1;
                  carry_in = 1'b0;
               end else if (pend_ff >= 5'(recc_pkg::PendingMax)) err_in = 1'b1;
               else pend_in = pend_ff + 5'd1;
               low_in = {low_ff[23:0], 8'd0};
            end
         end
         recc_pkg::ST_FL_TAIL: begin
            high_fl = {1'b0, low_ff} + range_ff;
            for (int k = 1; k <= 4; k++) begin
               basem = {1'b0, low_ff} | ((33'd1 << (8 * k)) - 33'd1);
               if (basem < high_fl) begin lw = basem[31:0]; tail = tail - 3'd1; end
            end
            csum = {1'b0, cache_ff} + {8'd0, carry_ff};
            eq_cache_in = cvalid_ff && (tail != 3'd0 || csum[7:0] != 8'hFF);
            eq_cbyte_in = csum[7:0];
            eq_pend_in  = (tail == 3'd0 && !carry_ff) ? 5'd0 : pend_ff;
            eq_pbyte_in = 8'hFF + {7'd0, carry_ff};
            eq_tail_in  = tail;
            eq_tword_in = lw;
         end
         recc_pkg::ST_FL_DONE: begin
            low_in = '0; carry_in = 1'b0; range_in = 33'h100000000;
            cache_in = '0; cvalid_in = 1'b0; pend_in = '0; err_in = 1'b0;
         end
         default: ;
      endcase
      // drop bytes past the per-word result limit
      if ((state_ff == recc_pkg::ST_NORM || state_ff == recc_pkg::ST_FL_EMIT) &&
          more && room == 6'd0) begin
         err_in = 1'b1;
         if (eq_cache_ff) eq_cache_in = 1'b0;
         else if (eq_pend_ff != 5'd0) eq_pend_in = eq_pend_ff - 5'd1;
         else begin eq_tail_in = eq_tail_ff - 3'd1; eq_tword_in = eq_tword_ff << 8; end
      end
      if (fire) begin
         nout_in = nout_ff + 5'd1;
         if (eq_cache_ff) eq_cache_in = 1'b0;
         else if (eq_pend_ff != 5'd0) eq_pend_in = eq_pend_ff - 5'd1;
         else begin eq_tail_in = eq_tail_ff - 3'd1; eq_tword_in = eq_tword_ff << 8; end
      end
   end

   always_comb begin
      req_tready = (state_ff == recc_pkg::ST_IDLE);
      rsp_tvalid = more && room != 6'd0 &&
                   (state_ff == recc_pkg::ST_EMIT || state_ff == recc_pkg::ST_FL_EMIT);
      rsp_tdata  = eq_cache_ff ? eq_cbyte_ff :
                   (eq_pend_ff != 5'd0) ? eq_pbyte_ff : eq_tword_ff[31:24];
      rsp_tuser  = err_ff;
      rsp_tlast  = 1'b0;
      if (state_ff == recc_pkg::ST_FL_EMIT) rsp_tlast = (room == 6'd1) || !more_after_fire();
      else rsp_tlast = (room == 6'd1) || (!more_after_fire() && final_norm());
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= recc_pkg::ST_IDLE;
         low_ff <= '0; carry_ff <= 1'b0; range_ff <= 33'h100000000;
         cache_ff <= '0; cvalid_ff <= 1'b0; pend_ff <= '0; err_ff <= 1'b0;
         eq_cache_ff <= 1'b0; eq_pend_ff <= '0; eq_tail_ff <= '0;
         nout_ff <= '0; div_phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         low_ff <= low_in; carry_ff <= carry_in; range_ff <= range_in;
         cache_ff <= cache_in; cvalid_ff <= cvalid_in; pend_ff <= pend_in;
         err_ff <= err_in;
         eq_cache_ff <= eq_cache_in; eq_pend_ff <= eq_pend_in; eq_tail_ff <= eq_tail_in;
         nout_ff <= nout_in; div_phase_ff <= div_phase_in;
      end
      if (accept) begin
         cum_ff <= req_tdata[15:0];
         frq_ff <= req_tdata[31:16];
         tot_ff <= req_tdata[47:32];
      end
      lo_ff <= lo_in; q_lo_ff <= q_lo_in;
      eq_cbyte_ff <= eq_cbyte_in; eq_pbyte_ff <= eq_pbyte_in; eq_tword_ff <= eq_tword_in;
   end

   `RECC_ASSERT_IMP(a_no_ready_busy, clock, reset, rsp_tvalid, !req_tready)
   `RECC_ASSERT_IMP(a_range_top, clock, reset, req_tready, range_ff >= 33'h001000000)
   `RECC_ASSERT_IMP(a_pend_bound, clock, reset, 1'b1,
                    pend_ff <= 5'(recc_pkg::PendingMax))
   `RECC_ASSERT_NEXT(a_flush_clears, clock, reset,
                     state_ff == recc_pkg::ST_FL_DONE, !err_ff && !cvalid_ff)
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

   typedef struct packed {
      logic [7:0] coded;
      logic       last;
      logic       ovf;
   } coded_byte_type;

   class coder_scoreboard;
      logic [31:0] low_q;
      logic        carry_q;
      logic [32:0] range_q;
      logic [7:0]  cache_q;
      logic        cache_ok;
      int          pend;
      logic        err;
      coded_byte_type byte_q[$];
      coded_byte_type item_bytes[$];
      int          mismatches;
      int          checked;

      function void clear();
         low_q = '0;
         carry_q = 1'b0;
         range_q = 33'h1_0000_0000;
         cache_q = '0;
         cache_ok = 1'b0;
         pend = 0;
         err = 1'b0;
      endfunction

      function void push_byte(logic [7:0] b);
         coded_byte_type c;
         if (item_bytes.size() >= recc_pkg::MaxResults) begin
            err = 1'b1;
            return;
         end
         c.coded = b;
         c.last = 1'b0;
         c.ovf = 1'b0;
         item_bytes.push_back(c);
      endfunction

      function void release_item();
         coded_byte_type c;
         for (int k = 0; k < item_bytes.size(); k++) begin
            c = item_bytes[k];
            c.last = (k == item_bytes.size() - 1);
            c.ovf = err;
            byte_q.push_back(c);
         end
         item_bytes.delete();
      endfunction

      function void shift_out();
         if (low_q < 32'hFF00_0000 || carry_q) begin
            if (cache_ok) push_byte(cache_q + carry_q);
            for (int i = 0; i < pend; i++) push_byte(8'hFF + carry_q);
            pend = 0;
            cache_q = low_q[31:24];
            cache_ok = 1'b1;
            carry_q = 1'b0;
         end else if (pend >= recc_pkg::PendingMax) begin
            err = 1'b1;
         end else begin
            pend++;
         end
         low_q = low_q << 8;
      endfunction

      function void flush_tail();
         int          tail;
         logic [63:0] base, high, mask;
         logic [31:0] lw;
         logic [7:0]  sum;
         tail = recc_pkg::TailBytes;
         base = {32'h0, low_q};
         high = base + {31'h0, range_q};
         lw = low_q;
         for (int k = 1; k <= 4; k++) begin
            mask = (64'h1 << (8 * k)) - 1;
            if ((base | mask) < high) begin
               lw = base[31:0] | mask[31:0];
               tail--;
            end
         end
         sum = cache_q + carry_q;
         if (cache_ok && (tail != 0 || sum != 8'hFF)) push_byte(sum);
         if (tail == 0 && !carry_q) pend = 0;
         for (int i = 0; i < pend; i++) push_byte(8'hFF + carry_q);
         for (int i = 0; i < tail; i++) begin
            push_byte(lw[31:24]);
            lw = lw << 8;
         end
         release_item();
         clear();
      endfunction

      function void note_word(logic action, logic [15:0] cf, logic [15:0] sf,
                              logic [15:0] tf);
         logic [64:0] lo, hi, sum;
         if (action == recc_pkg::ActFlush) begin
            flush_tail();
            return;
         end
         if (tf == 0 || sf == 0 || {1'b0, cf} + {1'b0, sf} > {1'b0, tf}) return;
         lo = range_q - (({32'h0, range_q} * (tf - cf)) / tf);
         hi = range_q - (({32'h0, range_q} * (tf - cf - sf)) / tf);
         sum = {carry_q, low_q} + lo;
         low_q = sum[31:0];
         carry_q = sum[32];
         range_q = hi[32:0] - lo[32:0];
         while (range_q < 33'h100_0000) begin
            range_q = range_q << 8;
            shift_out();
         end
         release_item();
      endfunction

      function void check_byte(logic [7:0] d, logic l, logic u);
         coded_byte_type e;
         checked++;
         if (byte_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected byte %h last %b ovf %b", d, l, u);
            return;
         end
         e = byte_q.pop_front();
         if (e.coded !== d || e.last !== l || e.ovf !== u) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp %h/%b/%b got %h/%b/%b",
                        e.coded, e.last, e.ovf, d, l, u);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   coder_scoreboard sb;
   bit   quiet = 1'b0;
   int   idle_cycles = 0;
   int   words_sent = 0;

   range_encoder_carry_cache_unit uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      sb = new();
      sb.clear();
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_byte(rsp_tdata, rsp_tlast, rsp_tuser);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 20000) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // output stall bursts
   initial begin
      int n;
      @(negedge clock);
      rsp_tready <= 1'b1;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 14);
            rsp_tready <= 1'b0;
            repeat (n) @(negedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_word(logic action, logic [15:0] cf, logic [15:0] sf,
                            logic [15:0] tf);
      int n;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, 14);
         req_tvalid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= action;
      req_tdata <= {tf, sf, cf};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_word(action, cf, sf, tf);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_symbol();
      logic [15:0] tf, cf, sf;
      int          m;
      m = $urandom_range(0, 9);
      if (m < 3) tf = 16'($urandom_range(1, 65535));
      else if (m < 6) tf = 16'($urandom_range(2, 300));
      else tf = 16'hFFFF;
      if ($urandom_range(0, 19) == 0) begin
         send_word(recc_pkg::ActEncode, 16'($urandom), 16'($urandom), 16'($urandom));
         return;
      end
      cf = 16'($urandom_range(0, tf - 1));
      m = $urandom_range(0, 3);
      if (m == 0) sf = 16'd1;
      else if (m == 1) sf = tf - cf;
      else sf = 16'($urandom_range(1, tf - cf));
      send_word(recc_pkg::ActEncode, cf, sf, tf);
   endtask

   initial begin
      int len;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed
      send_word(recc_pkg::ActFlush, 16'd0, 16'd0, 16'd0);
      send_word(recc_pkg::ActEncode, 16'd0, 16'hFFFF, 16'hFFFF);
      send_word(recc_pkg::ActEncode, 16'd0, 16'd0, 16'd10);
      send_word(recc_pkg::ActEncode, 16'd5, 16'd6, 16'd10);
      send_word(recc_pkg::ActEncode, 16'd0, 16'd5, 16'd0);
      send_word(recc_pkg::ActEncode, 16'hFFFE, 16'd1, 16'hFFFF);
      send_word(recc_pkg::ActEncode, 16'd0, 16'd1, 16'hFFFF);
      send_word(recc_pkg::ActEncode, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_word(recc_pkg::ActEncode, 16'd3, 16'd1, 16'd4);
      send_word(recc_pkg::ActFlush, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      for (int i = 0; i < 22; i++)
         send_word(recc_pkg::ActEncode, 16'hFFFE, 16'd1, 16'hFFFF);
      send_word(recc_pkg::ActFlush, 16'd0, 16'd0, 16'd0);
      for (int i = 0; i < 8; i++)
         send_word(recc_pkg::ActEncode, 16'hFFFF, 16'd1, 16'hFFFF);
      send_word(recc_pkg::ActFlush, 16'd0, 16'd0, 16'd0);
      // random frames of symbols, most ending in a flush
      while (words_sent < 310) begin
         len = $urandom_range(1, 12);
         if (words_sent > 270) quiet = 1'b1;
         for (int i = 0; i < len; i++) send_symbol();
         if ($urandom_range(0, 4) != 0)
            send_word(recc_pkg::ActFlush, 16'($urandom), 16'($urandom), 16'($urandom));
      end
      send_word(recc_pkg::ActFlush, 16'd0, 16'd0, 16'd0);
      req_tvalid <= 1'b0;
      while (sb.byte_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("Coded %0d words, checked %0d output bytes incl. carry and flush tails.",
               words_sent, sb.checked);
      if (sb.mismatches == 0 && sb.byte_q.size() == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule
`default_nettype wire
